@@ sv/rsla_pkg.sv @@
package rsla_pkg;

	// Width of the microprogram step counter.
	localparam int UPC_W = 5;

	typedef logic [UPC_W-1:0] upc_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Jump conditions of a control word.
	typedef enum logic [3:0] {
		J_NEXT,
		J_ALWAYS,
		J_FREE,
		J_FIRST,
		J_TAIL0,
		J_REUSE,
		J_FULL,
		J_EMPTY,
		J_RANGE,
		J_ONLY,
		J_IS_TAIL
	} jcond_t;

	// Read address of the forward link memory.
	typedef enum logic {
		RA_SLOT,
		RA_TAIL
	} raddr_t;

	// Write address of either link memory.
	typedef enum logic [2:0] {
		WA_ONE,
		WA_SLOT,
		WA_TAIL,
		WA_PREV,
		WA_NEXT,
		WA_LINK,
		WA_HW,
		WA_HW_NEXT
	} waddr_t;

	// Write data of either link memory.
	typedef enum logic [2:0] {
		WD_ZERO,
		WD_SLOT,
		WD_TAIL,
		WD_PREV_HEAD,
		WD_NEXT,
		WD_LINK,
		WD_HW_NEXT
	} wdata_t;

	// Write enable qualifiers.
	typedef enum logic [1:0] {
		WE_OFF,
		WE_ON,
		WE_NOT_HEAD,
		WE_LINK_NZ
	} we_t;

	// Register updates of the datapath; the END_ codes also set the result.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_HW_INC,
		OP_HEAD_STEP,
		OP_END_FIRST,
		OP_END_TAKE1,
		OP_END_REUSE,
		OP_END_GROW,
		OP_END_FULL,
		OP_END_EMPTY,
		OP_END_RANGE,
		OP_END_ONLY,
		OP_END_TAIL,
		OP_END_SPLICE
	} op_t;

	// Condition flags from the datapath to the sequencer.
	typedef struct packed {
		logic is_free;
		logic first_use;
		logic tail_zero;
		logic reuse;
		logic full;
		logic empty;
		logic bad_slot;
		logic only_one;
		logic is_tail;
	} cond_t;

	// One control word of the microprogram.
	typedef struct packed {
		jcond_t jcond;
		upc_t   jump;
		logic   b_re;
		logic   f_re;
		raddr_t f_ra;
		we_t    b_we;
		waddr_t b_wa;
		wdata_t b_wd;
		we_t    f_we;
		waddr_t f_wa;
		wdata_t f_wd;
		op_t    op;
		logic   fin;
	} ctrl_t;

	// Step addresses of the microprogram.
	localparam upc_t STEP_ENTRY    = upc_t'(0);
	localparam upc_t STEP_A_FIRST  = upc_t'(1);
	localparam upc_t STEP_A_TAIL0  = upc_t'(2);
	localparam upc_t STEP_A_REUSE  = upc_t'(3);
	localparam upc_t STEP_A_FULL   = upc_t'(4);
	localparam upc_t STEP_A_GROW1  = upc_t'(5);
	localparam upc_t STEP_A_GROW2  = upc_t'(6);
	localparam upc_t STEP_F0       = upc_t'(7);
	localparam upc_t STEP_F1       = upc_t'(8);
	localparam upc_t STEP_F2       = upc_t'(9);
	localparam upc_t STEP_F3       = upc_t'(10);
	localparam upc_t STEP_F4       = upc_t'(11);
	localparam upc_t STEP_F5       = upc_t'(12);
	localparam upc_t STEP_F6       = upc_t'(13);
	localparam upc_t STEP_E_FIRST  = upc_t'(14);
	localparam upc_t STEP_E_TAKE1  = upc_t'(15);
	localparam upc_t STEP_E_REUSE  = upc_t'(16);
	localparam upc_t STEP_E_FULL   = upc_t'(17);
	localparam upc_t STEP_E_EMPTY  = upc_t'(18);
	localparam upc_t STEP_E_RANGE  = upc_t'(19);
	localparam upc_t STEP_E_ONLY   = upc_t'(20);
	localparam upc_t STEP_E_TAIL   = upc_t'(21);

	// Control word that does nothing.
	localparam ctrl_t CTRL_IDLE = '{
		jcond: J_NEXT,
		jump:  STEP_ENTRY,
		b_re:  1'b0,
		f_re:  1'b0,
		f_ra:  RA_SLOT,
		b_we:  WE_OFF,
		b_wa:  WA_ONE,
		b_wd:  WD_ZERO,
		f_we:  WE_OFF,
		f_wa:  WA_ONE,
		f_wd:  WD_ZERO,
		op:    OP_NONE,
		fin:   1'b0
	};

	// The microprogram ROM.
	function automatic ctrl_t rom_word(input upc_t step);
		ctrl_t w;
		w = CTRL_IDLE;
		case (step)
			STEP_ENTRY: begin
				// Fetch the back link of the slot and the link after the tail.
				w.b_re  = 1'b1;
				w.f_re  = 1'b1;
				w.f_ra  = RA_TAIL;
				w.jcond = J_FREE;
				w.jump  = STEP_F0;
			end
			STEP_A_FIRST: begin
				w.jcond = J_FIRST;
				w.jump  = STEP_E_FIRST;
			end
			STEP_A_TAIL0: begin
				w.jcond = J_TAIL0;
				w.jump  = STEP_E_TAKE1;
			end
			STEP_A_REUSE: begin
				w.jcond = J_REUSE;
				w.jump  = STEP_E_REUSE;
			end
			STEP_A_FULL: begin
				w.jcond = J_FULL;
				w.jump  = STEP_E_FULL;
			end
			STEP_A_GROW1: begin
				w.f_we = WE_ON;
				w.f_wa = WA_TAIL;
				w.f_wd = WD_HW_NEXT;
				w.b_we = WE_ON;
				w.b_wa = WA_HW_NEXT;
				w.b_wd = WD_TAIL;
				w.op   = OP_HW_INC;
			end
			STEP_A_GROW2: begin
				w.f_we = WE_ON;
				w.f_wa = WA_HW;
				w.f_wd = WD_ZERO;
				w.op   = OP_END_GROW;
				w.fin  = 1'b1;
			end
			STEP_F0: begin
				w.f_re  = 1'b1;
				w.f_ra  = RA_SLOT;
				w.jcond = J_EMPTY;
				w.jump  = STEP_E_EMPTY;
			end
			STEP_F1: begin
				w.jcond = J_RANGE;
				w.jump  = STEP_E_RANGE;
			end
			STEP_F2: begin
				w.jcond = J_ONLY;
				w.jump  = STEP_E_ONLY;
			end
			STEP_F3: begin
				w.jcond = J_IS_TAIL;
				w.jump  = STEP_E_TAIL;
			end
			STEP_F4: begin
				// Unlink the slot and fetch the link after the tail.
				w.b_we = WE_ON;
				w.b_wa = WA_NEXT;
				w.b_wd = WD_PREV_HEAD;
				w.f_we = WE_NOT_HEAD;
				w.f_wa = WA_PREV;
				w.f_wd = WD_NEXT;
				w.f_re = 1'b1;
				w.f_ra = RA_TAIL;
				w.op   = OP_HEAD_STEP;
			end
			STEP_F5: begin
				w.f_we = WE_ON;
				w.f_wa = WA_TAIL;
				w.f_wd = WD_SLOT;
				w.b_we = WE_ON;
				w.b_wa = WA_SLOT;
				w.b_wd = WD_TAIL;
			end
			STEP_F6: begin
				w.f_we = WE_ON;
				w.f_wa = WA_SLOT;
				w.f_wd = WD_LINK;
				w.b_we = WE_LINK_NZ;
				w.b_wa = WA_LINK;
				w.b_wd = WD_SLOT;
				w.op   = OP_END_SPLICE;
				w.fin  = 1'b1;
			end
			STEP_E_FIRST: begin
				w.b_we = WE_ON;
				w.b_wa = WA_ONE;
				w.b_wd = WD_ZERO;
				w.f_we = WE_ON;
				w.f_wa = WA_ONE;
				w.f_wd = WD_ZERO;
				w.op   = OP_END_FIRST;
				w.fin  = 1'b1;
			end
			STEP_E_TAKE1: begin
				w.op  = OP_END_TAKE1;
				w.fin = 1'b1;
			end
			STEP_E_REUSE: begin
				w.op  = OP_END_REUSE;
				w.fin = 1'b1;
			end
			STEP_E_FULL: begin
				w.op  = OP_END_FULL;
				w.fin = 1'b1;
			end
			STEP_E_EMPTY: begin
				w.op  = OP_END_EMPTY;
				w.fin = 1'b1;
			end
			STEP_E_RANGE: begin
				w.op  = OP_END_RANGE;
				w.fin = 1'b1;
			end
			STEP_E_ONLY: begin
				w.op  = OP_END_ONLY;
				w.fin = 1'b1;
			end
			STEP_E_TAIL: begin
				w.op  = OP_END_TAIL;
				w.fin = 1'b1;
			end
			default: begin
				w.jcond = J_ALWAYS;
				w.jump  = STEP_ENTRY;
			end
		endcase
		return w;
	endfunction

endpackage

@@ sv/rsla_ram.sv @@
module rsla_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; a read sees the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/rsla_seq.sv @@
module rsla_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rsla_pkg::cond_t cond,
	output rsla_pkg::ctrl_t ctrl,
	output logic            busy
);

	import rsla_pkg::*;

	upc_t  upc_q;
	logic  busy_q;
	ctrl_t word;
	logic  taken;

	assign word = rom_word(upc_q);

	// Evaluate the jump condition of the current step.
	always_comb begin
		case (word.jcond)
			J_NEXT:    taken = 1'b0;
			J_ALWAYS:  taken = 1'b1;
			J_FREE:    taken = cond.is_free;
			J_FIRST:   taken = cond.first_use;
			J_TAIL0:   taken = cond.tail_zero;
			J_REUSE:   taken = cond.reuse;
			J_FULL:    taken = cond.full;
			J_EMPTY:   taken = cond.empty;
			J_RANGE:   taken = cond.bad_slot;
			J_ONLY:    taken = cond.only_one;
			J_IS_TAIL: taken = cond.is_tail;
			default:   taken = 1'b0;
		endcase
	end

	// Step counter: start from the entry step on a transfer, stop on the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= STEP_ENTRY;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				upc_q  <= STEP_ENTRY;
			end
		end else if (word.fin) begin
			busy_q <= 1'b0;
			upc_q  <= STEP_ENTRY;
		end else if (taken) begin
			upc_q <= word.jump;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

	// The datapath only sees live control words while an operation runs.
	assign ctrl = busy_q ? word : CTRL_IDLE;
	assign busy = busy_q;

endmodule

@@ sv/rsla_dp.sv @@
module rsla_dp #(
	parameter int  SLOT_CAPACITY = 1024,
	localparam int SLOT_W        = $clog2(SLOT_CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              kind,
	input  logic [SLOT_W-1:0] slot_number,
	input  rsla_pkg::ctrl_t   ctrl,
	output rsla_pkg::cond_t   cond,
	output logic              done,
	output logic [SLOT_W-1:0] result_slot,
	output logic [1:0]        status
);

	import rsla_pkg::*;

	localparam logic [SLOT_W-1:0] CAP = SLOT_W'(SLOT_CAPACITY);
	localparam logic [SLOT_W-1:0] ONE = SLOT_W'(1);

	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [SLOT_W-1:0] hw_q;
	logic [SLOT_W-1:0] live_q;
	logic              kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic              done_q;
	logic [SLOT_W-1:0] result_q;
	status_t           status_q;

	logic [SLOT_W-1:0] b_rdata;
	logic [SLOT_W-1:0] f_rdata;
	logic [SLOT_W-1:0] hw_next;
	logic [SLOT_W-1:0] f_raddr;
	logic [SLOT_W-1:0] b_waddr;
	logic [SLOT_W-1:0] b_wdata;
	logic [SLOT_W-1:0] f_waddr;
	logic [SLOT_W-1:0] f_wdata;
	logic              b_wen;
	logic              f_wen;
	logic              is_head;
	logic              link_nz;

	// The back link read holds the previous slot; the forward link read holds
	// the next slot, the slot after the tail, or the tail's old successor.
	assign hw_next = hw_q + 1'b1;
	assign is_head = (slot_q == head_q);
	assign link_nz = (f_rdata != '0);

	function automatic logic we_sel(input we_t w, input logic head, input logic nz);
		logic en;
		case (w)
			WE_OFF:      en = 1'b0;
			WE_ON:       en = 1'b1;
			WE_NOT_HEAD: en = !head;
			WE_LINK_NZ:  en = nz;
			default:     en = 1'b0;
		endcase
		return en;
	endfunction

	assign b_wen   = we_sel(ctrl.b_we, is_head, link_nz);
	assign f_wen   = we_sel(ctrl.f_we, is_head, link_nz);
	assign f_raddr = (ctrl.f_ra == RA_TAIL) ? tail_q : slot_q;

	// Back link write address and data.
	always_comb begin
		case (ctrl.b_wa)
			WA_ONE:     b_waddr = ONE;
			WA_SLOT:    b_waddr = slot_q;
			WA_TAIL:    b_waddr = tail_q;
			WA_PREV:    b_waddr = b_rdata;
			WA_NEXT:    b_waddr = f_rdata;
			WA_LINK:    b_waddr = f_rdata;
			WA_HW:      b_waddr = hw_q;
			WA_HW_NEXT: b_waddr = hw_next;
			default:    b_waddr = '0;
		endcase
		case (ctrl.b_wd)
			WD_ZERO:      b_wdata = '0;
			WD_SLOT:      b_wdata = slot_q;
			WD_TAIL:      b_wdata = tail_q;
			WD_PREV_HEAD: b_wdata = is_head ? '0 : b_rdata;
			WD_NEXT:      b_wdata = f_rdata;
			WD_LINK:      b_wdata = f_rdata;
			WD_HW_NEXT:   b_wdata = hw_next;
			default:      b_wdata = '0;
		endcase
	end

	// Forward link write address and data.
	always_comb begin
		case (ctrl.f_wa)
			WA_ONE:     f_waddr = ONE;
			WA_SLOT:    f_waddr = slot_q;
			WA_TAIL:    f_waddr = tail_q;
			WA_PREV:    f_waddr = b_rdata;
			WA_NEXT:    f_waddr = f_rdata;
			WA_LINK:    f_waddr = f_rdata;
			WA_HW:      f_waddr = hw_q;
			WA_HW_NEXT: f_waddr = hw_next;
			default:    f_waddr = '0;
		endcase
		case (ctrl.f_wd)
			WD_ZERO:      f_wdata = '0;
			WD_SLOT:      f_wdata = slot_q;
			WD_TAIL:      f_wdata = tail_q;
			WD_PREV_HEAD: f_wdata = is_head ? '0 : b_rdata;
			WD_NEXT:      f_wdata = f_rdata;
			WD_LINK:      f_wdata = f_rdata;
			WD_HW_NEXT:   f_wdata = hw_next;
			default:      f_wdata = '0;
		endcase
	end

	rsla_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_CAPACITY + 1)
	) u_back_ram (
		.clk   (clk),
		.we    (b_wen),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (ctrl.b_re),
		.raddr (slot_q),
		.rdata (b_rdata)
	);

	rsla_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_CAPACITY + 1)
	) u_fwd_ram (
		.clk   (clk),
		.we    (f_wen),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (ctrl.f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	// Conditions for the sequencer's jumps.
	assign cond.is_free   = kind_q;
	assign cond.first_use = (tail_q == '0) && (hw_q == '0);
	assign cond.tail_zero = (tail_q == '0);
	assign cond.reuse     = link_nz && (live_q < CAP);
	assign cond.full      = (hw_q >= CAP) || (live_q >= CAP);
	assign cond.empty     = (live_q == '0);
	assign cond.bad_slot  = (slot_q == '0) || (slot_q > CAP);
	assign cond.only_one  = (live_q == ONE);
	assign cond.is_tail   = (slot_q == tail_q);

	// List state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= ONE;
			tail_q <= '0;
			hw_q   <= '0;
			live_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.fin;
			case (ctrl.op)
				OP_HW_INC: begin
					hw_q <= hw_next;
				end
				OP_HEAD_STEP: begin
					if (is_head) begin
						head_q <= f_rdata;
					end
				end
				OP_END_FIRST: begin
					tail_q <= ONE;
					hw_q   <= ONE;
					live_q <= live_q + 1'b1;
				end
				OP_END_TAKE1: begin
					tail_q <= ONE;
					live_q <= live_q + 1'b1;
				end
				OP_END_REUSE: begin
					tail_q <= f_rdata;
					live_q <= live_q + 1'b1;
				end
				OP_END_GROW: begin
					tail_q <= hw_q;
					live_q <= live_q + 1'b1;
				end
				OP_END_ONLY: begin
					live_q <= '0;
					tail_q <= '0;
					head_q <= ONE;
					hw_q   <= '0;
				end
				OP_END_TAIL: begin
					tail_q <= b_rdata;
					live_q <= live_q - 1'b1;
				end
				OP_END_SPLICE: begin
					live_q <= live_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Command capture and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			slot_q <= slot_number;
		end
		case (ctrl.op)
			OP_END_FIRST, OP_END_TAKE1: begin
				result_q <= ONE;
				status_q <= ST_OK;
			end
			OP_END_REUSE: begin
				result_q <= f_rdata;
				status_q <= ST_OK;
			end
			OP_END_GROW: begin
				result_q <= hw_q;
				status_q <= ST_OK;
			end
			OP_END_FULL: begin
				result_q <= '0;
				status_q <= ST_FULL;
			end
			OP_END_EMPTY: begin
				result_q <= '0;
				status_q <= ST_EMPTY;
			end
			OP_END_RANGE: begin
				result_q <= '0;
				status_q <= ST_RANGE;
			end
			OP_END_ONLY, OP_END_TAIL, OP_END_SPLICE: begin
				result_q <= slot_q;
				status_q <= ST_OK;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign result_slot = result_q;
	assign status      = status_q;

endmodule

@@ sv/record_slot_list_allocator.sv @@
// Record slot allocator over one doubly linked chain of slots 1..SLOT_CAPACITY.
// A command is taken when start is high and busy is low; its single result
// appears on result_slot and status for exactly one cycle with done high, and
// the receiver cannot stall it. A microprogram walks each command through the
// two link memories (one write port each); an allocate takes longest when it
// extends the chain past the high-water mark, and a free when it unlinks the
// slot and splices it in after the tail. busy drops with done, so the next
// command can be taken in the done cycle. The link memories are not cleared
// after reset; the head, tail, high-water mark and live count are reset.
module record_slot_list_allocator #(
	parameter int  SLOT_CAPACITY = 1024,
	localparam int SLOT_W        = $clog2(SLOT_CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [SLOT_W-1:0] slot_number,
	output logic              done,
	output logic [SLOT_W-1:0] result_slot,
	output logic [1:0]        status
);

	import rsla_pkg::*;

	ctrl_t ctrl;
	cond_t cond;
	logic  accept;

	// A command transfer.
	assign accept = start && !busy;

	rsla_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cond   (cond),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	rsla_dp #(
		.SLOT_CAPACITY (SLOT_CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.slot_number (slot_number),
		.ctrl        (ctrl),
		.cond        (cond),
		.done        (done),
		.result_slot (result_slot),
		.status      (status)
	);

endmodule

@@ verif/rsla_tb_pkg.sv @@
package rsla_tb_pkg;

	// Command codes carried on the kind port.
	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

endpackage

@@ verif/slot_chain_checker.sv @@
module slot_chain_checker #(
	parameter int CAPACITY = 1024,
	parameter int SLOT_W   = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              kind,
	input  logic [SLOT_W-1:0] slot_number,
	input  logic              done,
	input  logic [SLOT_W-1:0] result_slot,
	input  logic [1:0]        status,
	output int                mismatches,
	output int                awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import rsla_pkg::*;
	import rsla_tb_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           st;
	} outcome_t;

	// Shadow copy of the slot chain.
	logic [SLOT_W-1:0] back_of [0:CAPACITY];
	logic [SLOT_W-1:0] fwd_of [0:CAPACITY];
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [SLOT_W-1:0] high_mark;
	logic [SLOT_W-1:0] live_n;

	outcome_t          pending_outcomes [$];
	outcome_t          want;
	logic [SLOT_W-1:0] got;
	status_t           verdict;
	int                errs;

	// Return the chain to its empty shape; the live count is handled by the caller.
	function automatic void reset_chain();
		tail_q    = '0;
		head_q    = SLOT_W'(1);
		high_mark = '0;
	endfunction

	function automatic void model_allocate(output logic [SLOT_W-1:0] slot,
			output status_t st);
		logic [SLOT_W-1:0] after;
		slot = '0;
		st   = ST_OK;
		if (tail_q == 0 && high_mark == 0) begin
			// Empty structure: slot 1 starts a fresh chain.
			back_of[1] = '0;
			fwd_of[1]  = '0;
			tail_q     = SLOT_W'(1);
			high_mark  = SLOT_W'(1);
		end else if (tail_q == 0) begin
			tail_q = SLOT_W'(1);
		end else begin
			after = fwd_of[tail_q];
			if (after != 0 && live_n < CAPACITY) begin
				// Reuse the freed slot that follows the tail.
				tail_q = after;
			end else if (high_mark >= CAPACITY || live_n >= CAPACITY) begin
				st = ST_FULL;
			end else begin
				// Extend the chain past the high-water mark.
				high_mark         = high_mark + 1'b1;
				fwd_of[tail_q]    = high_mark;
				back_of[high_mark] = tail_q;
				fwd_of[high_mark] = '0;
				tail_q            = high_mark;
			end
		end
		if (st == ST_OK) begin
			live_n = live_n + 1'b1;
			slot   = tail_q;
		end
	endfunction

	function automatic void model_release(input logic [SLOT_W-1:0] s, output status_t st);
		logic [SLOT_W-1:0] prev;
		logic [SLOT_W-1:0] nxt;
		logic [SLOT_W-1:0] after;
		st = ST_OK;
		if (live_n == 0) begin
			st = ST_EMPTY;
		end else if (s == 0 || s > CAPACITY) begin
			st = ST_RANGE;
		end else if (live_n == 1) begin
			// Freeing the only live slot empties everything, whichever slot is named.
			live_n = '0;
			reset_chain();
		end else begin
			prev = back_of[s];
			nxt  = fwd_of[s];
			if (s == tail_q) begin
				// The tail simply steps back; the slot stays chained behind it.
				tail_q = back_of[tail_q];
				live_n = live_n - 1'b1;
				if (live_n == 0)
					reset_chain();
			end else begin
				if (s == head_q) begin
					head_q       = nxt;
					back_of[nxt] = '0;
				end else begin
					back_of[nxt] = prev;
					fwd_of[prev] = nxt;
				end
				// Splice the slot in straight after the tail.
				after          = fwd_of[tail_q];
				fwd_of[tail_q] = s;
				back_of[s]     = tail_q;
				fwd_of[s]      = after;
				if (after != 0)
					back_of[after] = s;
				live_n = live_n - 1'b1;
			end
		end
	endfunction

	// Results are compared before a transfer in the same cycle is predicted,
	// since any result that is out belongs to an older command.
	always @(posedge clk) begin
		if (!arst_n) begin
			live_n = '0;
			reset_chain();
			pending_outcomes.delete();
			mismatches <= 0;
			awaiting   <= 0;
		end else begin
			errs = mismatches;
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual slot %0d status %0d",
						$time, result_slot, status);
					errs++;
				end else begin
					want = pending_outcomes.pop_front();
					if (result_slot !== want.slot) begin
						$display("%0t: result_slot mismatch, expected %0d, actual %0d",
							$time, want.slot, result_slot);
						errs++;
					end
					if (status !== want.st) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.st, status);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				if (kind == KIND_ALLOC) begin
					model_allocate(got, verdict);
				end else begin
					model_release(slot_number, verdict);
					got = slot_number;
				end
				if (verdict != ST_OK)
					got = '0;
				pending_outcomes.insert(pending_outcomes.size(),
					outcome_t'{slot: got, st: verdict});
			end
			mismatches <= errs;
			awaiting   <= pending_outcomes.size();
		end
	end

endmodule

@@ verif/record_slot_list_allocator_tb.sv @@
module record_slot_list_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsla_pkg::*;
	import rsla_tb_pkg::*;

	localparam int CAPACITY     = 1024;
	localparam int SLOT_W       = 11;
	localparam int SLOT_MAX     = 2047;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int FULL_HITS    = 5;
	localparam int ITEM_CAP     = 3000;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              kind        = 1'b0;
	logic [SLOT_W-1:0] slot_number = '0;
	logic              busy;
	logic              done;
	logic [SLOT_W-1:0] result_slot;
	logic [1:0]        status;
	int                mismatches;
	int                awaiting;

	// Commands in flight, in order, and the slots known to be live.
	kind_t             in_flight [$];
	logic [SLOT_W-1:0] live_slots [$];
	int                allocs_in_flight = 0;
	bit                busy_seen;
	bit                no_gaps = 1'b0;
	int                stall_cycles = 0;
	int                items = 0;
	int                n_alloc = 0;
	int                n_free = 0;
	int                full_hits = 0;
	int                empty_hits = 0;
	int                range_hits = 0;

	record_slot_list_allocator #(
		.SLOT_CAPACITY(CAPACITY)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.slot_number(slot_number),
		.done       (done),
		.result_slot(result_slot),
		.status     (status)
	);

	slot_chain_checker #(
		.CAPACITY(CAPACITY),
		.SLOT_W  (SLOT_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.slot_number(slot_number),
		.done       (done),
		.result_slot(result_slot),
		.status     (status),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Abandon the run if neither a transfer nor a result happens for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else if (arst_n)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer or result for %0d cycles", $time, stall_cycles);
			$display("record_slot_list_allocator_tb NOT OK");
			$finish;
		end
	end

	// One clock edge; results are used to keep track of which slots are live.
	task automatic tick();
		kind_t k;
		@(posedge clk);
		busy_seen = busy;
		if (done && in_flight.size() > 0) begin
			k = in_flight.pop_front();
			if (k == KIND_ALLOC) begin
				allocs_in_flight--;
				if (status == ST_OK)
					live_slots.insert(live_slots.size(), result_slot);
				else if (status == ST_FULL)
					full_hits++;
			end else if (status == ST_EMPTY) begin
				empty_hits++;
			end else if (status == ST_RANGE) begin
				range_hits++;
			end
		end
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) tick();
		end
	endtask

	// Draw an idle gap, present the command and hold it until the transfer.
	task automatic send_command(input kind_t k, input logic [SLOT_W-1:0] s);
		if (items % 64 == 0)
			no_gaps = ($urandom_range(0, 3) == 0);
		pause(no_gaps ? 0 : $urandom_range(0, 9));
		kind        <= k;
		slot_number <= s;
		start       <= 1'b1;
		do
			tick();
		while (busy_seen);
		in_flight.insert(in_flight.size(), k);
		items++;
		if (k == KIND_ALLOC) begin
			allocs_in_flight++;
			n_alloc++;
		end else begin
			n_free++;
		end
	endtask

	// Frees must know every allocated slot, so outstanding allocates finish first.
	task automatic settle_allocs();
		if (allocs_in_flight > 0) begin
			start <= 1'b0;
			while (allocs_in_flight > 0)
				tick();
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (in_flight.size() > 0)
			tick();
	endtask

	task automatic alloc_command();
		send_command(KIND_ALLOC, SLOT_W'($urandom_range(0, SLOT_MAX)));
	endtask

	task automatic free_command(input logic [SLOT_W-1:0] s);
		int i;
		settle_allocs();
		if (s >= 1 && s <= CAPACITY) begin
			// With one slot live any in-range free empties the whole chain.
			if (live_slots.size() == 1) begin
				live_slots.delete();
			end else begin
				for (i = 0; i < live_slots.size(); i++) begin
					if (live_slots[i] == s) begin
						live_slots.delete(i);
						break;
					end
				end
			end
		end
		send_command(KIND_FREE, s);
	endtask

	// A random allocate or free; frees mostly name live slots, with some out-of-range numbers mixed in.
	task automatic random_command(input int alloc_pct);
		int                roll;
		logic [SLOT_W-1:0] s;
		if ($urandom_range(0, 99) < alloc_pct) begin
			alloc_command();
		end else begin
			settle_allocs();
			roll = $urandom_range(0, 99);
			if (live_slots.size() == 0)
				s = SLOT_W'($urandom_range(0, SLOT_MAX));
			else if (roll < 3)
				s = '0;
			else if (roll < 7)
				s = SLOT_W'($urandom_range(CAPACITY + 1, SLOT_MAX));
			else if (live_slots.size() == 1 && roll < 40)
				s = SLOT_W'($urandom_range(1, CAPACITY));
			else
				s = live_slots[$urandom_range(0, live_slots.size() - 1)];
			free_command(s);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Frees with nothing live, then range errors and the only-slot free.
		free_command(SLOT_W'(5));
		free_command('0);
		alloc_command();
		free_command('0);
		free_command(SLOT_W'(SLOT_MAX));
		free_command(SLOT_W'(CAPACITY + 1));
		free_command(SLOT_W'(CAPACITY));
		// Grow to four slots, then free the head, a middle slot and the tail.
		repeat (4) alloc_command();
		free_command(SLOT_W'(1));
		free_command(SLOT_W'(3));
		free_command(SLOT_W'(4));
		// Reuse the freed slots, grow once more, then unwind to empty.
		repeat (4) alloc_command();
		free_command(SLOT_W'(2));
		free_command(SLOT_W'(5));
		free_command(SLOT_W'(4));
		free_command(SLOT_W'(1));
		free_command(SLOT_W'(3));
		alloc_command();
		drain();

		// Churn on a short chain, then fill to capacity and work around full.
		repeat (50) random_command(50);
		drain();
		while (full_hits < FULL_HITS && items < ITEM_CAP)
			random_command(98);
		repeat (30) random_command(60);

		drain();
		tick();
		while (awaiting != 0)
			tick();
		repeat (DRAIN_CYCLES) tick();

		$display("Sent %0d commands: %0d allocates and %0d frees, filling the chain to %0d slots.",
			items, n_alloc, n_free, CAPACITY);
		$display("Seen %0d store-full, %0d nothing-live and %0d out-of-range answers.",
			full_hits, empty_hits, range_hits);
		if (mismatches == 0 && awaiting == 0) begin
			$display("record_slot_list_allocator_tb OK");
		end else begin
			$display("%0t: %0d mismatches, %0d results outstanding", $time, mismatches,
				awaiting);
			$display("record_slot_list_allocator_tb NOT OK");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/rsla_pkg.sv
sv/rsla_ram.sv
sv/rsla_seq.sv
sv/rsla_dp.sv
sv/record_slot_list_allocator.sv
verif/rsla_tb_pkg.sv
verif/slot_chain_checker.sv
verif/record_slot_list_allocator_tb.sv
